>>> src/tmdsg_pkg.sv
package tmdsg_pkg;

    localparam int MAX_GRID_BITS = 9;
    localparam int MAX_FRAC_BITS = 24;
    localparam int POS_W         = 22;
    localparam int MASS_W        = 16;
    localparam int CELL_W        = 18;
    localparam int ICV_W         = 32;
    localparam int RATE_W        = 40;
    localparam int RATE_LO_W     = 20;
    localparam int GRID_W        = 40;
    localparam int MASS_SUM_W    = 48;
    localparam int CELL_IDX_W    = 3 * MAX_GRID_BITS;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int IN_TDATA_W    = 104;
    localparam int IN_TUSER_W    = 2;
    localparam int OUT_TDATA_W   = 136;

    localparam logic [ICV_W-1:0] ICV_RESET = 32'h0001_0000;

    typedef enum logic {
        OP_DEPOSIT = 1'b0,
        OP_READ    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CALC,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ISSUE,
        BK_WAIT
    } back_state_t;

    typedef logic [MAX_FRAC_BITS-1:0] weight_t;

    // One classified work item; narrower configurations use the low bits.
    typedef struct packed {
        op_t                     op;
        logic                    half;
        logic [MAX_GRID_BITS-1:0] node_x;
        logic [MAX_GRID_BITS-1:0] node_y;
        logic [MAX_GRID_BITS-1:0] node_z;
        weight_t [2:0]           wx;
        weight_t [2:0]           wy;
        weight_t [2:0]           wz;
        logic [RATE_W-1:0]       rate;
        logic [MASS_W-1:0]       mass;
        logic [CELL_IDX_W-1:0]   read_cell;
    } work_item_t;

endpackage

>>> src/tsc_mass_deposit_split_grid_core.sv
// Channel   Direction  Handshake                      Content
// s_axis    in         s_axis_tvalid / s_axis_tready  particle deposit or cell read
// m_axis    out        m_axis_tvalid / m_axis_tready  grid values, mass total, flag
// cfg       in         cfg_valid / cfg_ready          inverse cell volume, Q16.16
//
// A deposit issues its 27 stencil cells into the grid memory one by one, then the
// multiply and read-modify-write pipeline drains; the next work item starts only after
// the result has left m_axis. A read issues a single cell through the same pipeline.
// The back end takes one work item at a time and waits for that pipeline to drain.
// After reset all 2^(3*GRID_BITS) cells of the memory are cleared with s_axis_tready low.
// The front classifier keeps accepting while a result waits on m_axis, until the queue fills.
module tsc_mass_deposit_split_grid_core #(
    parameter int GRID_BITS = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pos_x[21:0], pos_y[43:22], pos_z[65:44], particle_mass[81:66], cell_index[99:82]
    input  logic [tmdsg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation[0], half_select[1]
    input  logic [tmdsg_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // first_grid_value[39:0], second_grid_value[79:40], mass_sum[127:80], saturated[128]
    output logic [tmdsg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tmdsg_pkg::ICV_W-1:0]          cfg_data
);
    import tmdsg_pkg::*;

    logic [ICV_W-1:0]      icv_reg;
    logic                  clearing;
    logic                  q_push_valid, q_push_ready;
    work_item_t            q_push_item;
    logic                  q_pop_valid, q_pop_ready;
    work_item_t            q_pop_item;
    logic [GRID_W-1:0]     first_val, second_val;
    logic [MASS_SUM_W-1:0] mass_sum;
    logic                  saturated;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icv_reg <= ICV_RESET;
        end
        else if (cfg_valid)
        begin
            icv_reg <= cfg_data;
        end
    end

    tmdsg_front #(
        .GRID_BITS (GRID_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (op_t'(s_axis_tuser[0])),
        .in_pos_x   (s_axis_tdata[21:0]),
        .in_pos_y   (s_axis_tdata[43:22]),
        .in_pos_z   (s_axis_tdata[65:44]),
        .in_mass    (s_axis_tdata[81:66]),
        .in_half    (s_axis_tuser[1]),
        .in_cell    (s_axis_tdata[99:82]),
        .icv        (icv_reg),
        .clearing   (clearing),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item)
    );

    tmdsg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    tmdsg_back #(
        .GRID_BITS (GRID_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (q_pop_valid),
        .pop_ready     (q_pop_ready),
        .pop_item      (q_pop_item),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_first     (first_val),
        .out_second    (second_val),
        .out_mass_sum  (mass_sum),
        .out_saturated (saturated),
        .clearing      (clearing)
    );

    assign m_axis_tdata = {7'b0, saturated, mass_sum, second_val, first_val};

    a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready)
        else $error("input accepted during grid clear");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !m_axis_tvalid)
        else $error("result presented during grid clear");

    a_pop_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop_valid && q_pop_ready) |-> !m_axis_tvalid)
        else $error("work item started while a result is still pending");

endmodule

>>> src/tmdsg_front.sv
module tmdsg_front #(
    parameter int GRID_BITS = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  tmdsg_pkg::op_t                   in_op,
    input  logic [tmdsg_pkg::POS_W-1:0]      in_pos_x,
    input  logic [tmdsg_pkg::POS_W-1:0]      in_pos_y,
    input  logic [tmdsg_pkg::POS_W-1:0]      in_pos_z,
    input  logic [tmdsg_pkg::MASS_W-1:0]     in_mass,
    input  logic                             in_half,
    input  logic [tmdsg_pkg::CELL_W-1:0]     in_cell,
    input  logic [tmdsg_pkg::ICV_W-1:0]      icv,
    input  logic                             clearing,
    output logic                             push_valid,
    input  logic                             push_ready,
    output tmdsg_pkg::work_item_t            push_item
);
    import tmdsg_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int EXT_W = POS_W + FRAC_BITS + GRID_BITS;
    localparam logic [F:0]     ONE     = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0]   HALF    = {1'b1, {(F-1){1'b0}}};
    localparam logic [2*F-1:0] THREE_Q = {2'b11, {(2*F-2){1'b0}}};

    front_state_t              state_reg, state_next;
    logic [1:0]                step_reg, step_next;
    logic [2:0][POS_W-1:0]     pos_reg;
    work_item_t                item_reg, item_next;
    logic                      load;

    logic [POS_W-1:0]          pos_sel;
    logic [EXT_W-1:0]          pos_ext;
    logic [F-1:0]              d;
    logic                      up;
    logic [GRID_BITS-1:0]      cell_c;
    logic [GRID_BITS-1:0]      node;
    logic [F-1:0]              s;
    logic [F:0]                a;
    logic [F-1:0]              b;
    logic [2*F+1:0]            aa;
    logic [2*F-1:0]            bb;
    logic [2*F-1:0]            ss;
    logic [F-1:0]              wa, wb, wc, w_lo, w_hi;
    logic [RATE_W+8-1:0]       rate_prod;

    // Weights of one axis; the axis is picked by the step counter.
    assign pos_sel = pos_reg[step_reg];
    assign pos_ext = EXT_W'(pos_sel);
    assign d       = pos_ext[F-1:0];
    assign up      = d[F-1];
    assign cell_c  = pos_ext[F +: GRID_BITS];
    assign node    = cell_c + GRID_BITS'(up);
    assign s       = up ? F'(ONE - {1'b0, d}) : d;
    assign a       = {1'b0, HALF} + {1'b0, s};
    assign b       = HALF - s;
    assign aa      = a * a;
    assign bb      = b * b;
    assign ss      = s * s;
    assign wa      = aa[2*F:F+1];
    assign wb      = F'(bb >> (F + 1));
    assign wc      = F'((THREE_Q - ss) >> F);
    assign w_lo    = up ? wa : wb;
    assign w_hi    = up ? wb : wa;

    assign rate_prod = item_reg.mass * icv;

    always_comb
    begin
        push_item      = item_reg;
        push_item.rate = rate_prod[RATE_W+8-1:8];
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        item_next  = item_reg;
        in_ready   = 1'b0;
        push_valid = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            FR_IDLE:
            begin
                in_ready = !clearing;
                if (in_valid && !clearing)
                begin
                    load                = 1'b1;
                    item_next.op        = in_op;
                    item_next.half      = in_half;
                    item_next.mass      = in_mass;
                    item_next.read_cell = CELL_IDX_W'(in_cell);
                    step_next           = 2'd0;
                    state_next          = (in_op == OP_READ) ? FR_PUSH : FR_CALC;
                end
            end
            FR_CALC:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        item_next.node_x = MAX_GRID_BITS'(node);
                        item_next.wx[0]  = MAX_FRAC_BITS'(w_lo);
                        item_next.wx[1]  = MAX_FRAC_BITS'(wc);
                        item_next.wx[2]  = MAX_FRAC_BITS'(w_hi);
                    end
                    2'd1:
                    begin
                        item_next.node_y = MAX_GRID_BITS'(node);
                        item_next.wy[0]  = MAX_FRAC_BITS'(w_lo);
                        item_next.wy[1]  = MAX_FRAC_BITS'(wc);
                        item_next.wy[2]  = MAX_FRAC_BITS'(w_hi);
                    end
                    default:
                    begin
                        item_next.node_z = MAX_GRID_BITS'(node);
                        item_next.wz[0]  = MAX_FRAC_BITS'(w_lo);
                        item_next.wz[1]  = MAX_FRAC_BITS'(wc);
                        item_next.wz[2]  = MAX_FRAC_BITS'(w_hi);
                    end
                endcase
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (load)
        begin
            pos_reg[0] <= in_pos_x;
            pos_reg[1] <= in_pos_y;
            pos_reg[2] <= in_pos_z;
        end
    end

endmodule

>>> src/tmdsg_queue.sv
module tmdsg_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  tmdsg_pkg::work_item_t push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output tmdsg_pkg::work_item_t pop_item
);
    import tmdsg_pkg::*;

    work_item_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push, do_pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/tmdsg_back.sv
module tmdsg_back #(
    parameter int GRID_BITS = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  tmdsg_pkg::work_item_t             pop_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tmdsg_pkg::GRID_W-1:0]      out_first,
    output logic [tmdsg_pkg::GRID_W-1:0]      out_second,
    output logic [tmdsg_pkg::MASS_SUM_W-1:0]  out_mass_sum,
    output logic                              out_saturated,
    output logic                              clearing
);
    import tmdsg_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int G      = GRID_BITS;
    localparam int ADDR_W = 3 * GRID_BITS;
    localparam int CELLS  = 1 << ADDR_W;
    localparam int PROD_W = RATE_W + FRAC_BITS;
    localparam int PART_W = RATE_LO_W + FRAC_BITS;
    localparam logic [1:0] LAST_TAP = 2'd2;

    // Both grids share one word so that a read returns them together.
    logic [2*GRID_W-1:0]   grid_mem [CELLS];
    logic [2*GRID_W-1:0]   rdata_reg;

    back_state_t           state_reg, state_next;
    work_item_t            item_reg;
    logic [1:0]            ci_reg, cj_reg, ck_reg;
    logic [1:0]            ci_next, cj_next, ck_next;
    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic [MASS_SUM_W-1:0] mass_total_reg, mass_total_next;
    logic                  sat_reg, sat_next;
    logic                  do_pop;
    logic [MASS_SUM_W:0]   mass_sum_wide;

    logic                  s0_valid, s0_last;
    logic [G-1:0]          cx, cy, cz;
    logic [ADDR_W-1:0]     s0_addr;
    logic [2*F-1:0]        s0_p1;

    logic                  s1_valid_reg, s1_last_reg, s1_read_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [F-1:0]          s1_wz_reg;
    logic [2*F-1:0]        s1_p1_reg;

    logic                  s2_valid_reg, s2_last_reg, s2_read_reg;
    logic [ADDR_W-1:0]     s2_addr_reg;
    logic [2*F-1:0]        s2_p2_reg;

    logic                  s3_valid_reg, s3_last_reg, s3_read_reg;
    logic [ADDR_W-1:0]     s3_addr_reg;
    logic [PART_W-1:0]     s3_hi_reg, s3_lo_reg;
    logic [F-1:0]          s2_w;
    logic [PROD_W-1:0]     s3_full;

    logic                  s4_valid_reg, s4_last_reg, s4_read_reg;
    logic [ADDR_W-1:0]     s4_addr_reg;
    logic [GRID_W-1:0]     s4_amt_reg;

    logic [GRID_W-1:0]     old_val, new_val;
    logic [GRID_W:0]       sum_wide;
    logic                  grid_sat;
    logic                  wr_en;
    logic [2*GRID_W-1:0]   wr_word;

    logic                  out_valid_reg;
    logic [GRID_W-1:0]     out_first_reg, out_second_reg;
    logic [MASS_SUM_W-1:0] out_mass_sum_reg;
    logic                  out_saturated_reg;

    assign clearing  = state_reg == BK_CLEAR;
    assign pop_ready = (state_reg == BK_IDLE) && !out_valid_reg;
    assign do_pop    = pop_valid && pop_ready;

    // Issue stage: one cell of the 3x3x3 stencil per cycle.
    assign s0_valid = state_reg == BK_ISSUE;
    assign s0_last  = (item_reg.op == OP_READ)
                   || (ci_reg == LAST_TAP && cj_reg == LAST_TAP && ck_reg == LAST_TAP);
    assign cx = item_reg.node_x[G-1:0] + G'(ci_reg) - G'(1);
    assign cy = item_reg.node_y[G-1:0] + G'(cj_reg) - G'(1);
    assign cz = item_reg.node_z[G-1:0] + G'(ck_reg) - G'(1);
    assign s0_addr = (item_reg.op == OP_READ) ? item_reg.read_cell[ADDR_W-1:0]
                                              : {cx, cy, cz};
    assign s0_p1   = item_reg.wx[ci_reg][F-1:0] * item_reg.wy[cj_reg][F-1:0];

    assign s2_w    = s2_p2_reg[2*F-1:F];
    assign s3_full = (PROD_W'(s3_hi_reg) << RATE_LO_W) + PROD_W'(s3_lo_reg);

    assign old_val  = item_reg.half ? rdata_reg[2*GRID_W-1:GRID_W] : rdata_reg[GRID_W-1:0];
    assign sum_wide = {1'b0, old_val} + {1'b0, s4_amt_reg};
    assign grid_sat = s4_valid_reg && !s4_read_reg && sum_wide[GRID_W];
    assign new_val  = sum_wide[GRID_W] ? {GRID_W{1'b1}} : sum_wide[GRID_W-1:0];
    assign wr_en    = s4_valid_reg && !s4_read_reg;
    assign wr_word  = item_reg.half ? {new_val, rdata_reg[GRID_W-1:0]}
                                    : {rdata_reg[2*GRID_W-1:GRID_W], new_val};

    assign mass_sum_wide = {1'b0, mass_total_reg} + (MASS_SUM_W + 1)'(pop_item.mass);

    always_comb
    begin
        state_next      = state_reg;
        ci_next         = ci_reg;
        cj_next         = cj_reg;
        ck_next         = ck_reg;
        mass_total_next = mass_total_reg;
        sat_next        = sat_reg | grid_sat;
        unique case (state_reg)
            BK_CLEAR:
            begin
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (do_pop)
                begin
                    ci_next    = 2'd0;
                    cj_next    = 2'd0;
                    ck_next    = 2'd0;
                    state_next = BK_ISSUE;
                    if (pop_item.op == OP_DEPOSIT)
                    begin
                        if (mass_sum_wide[MASS_SUM_W])
                        begin
                            mass_total_next = {MASS_SUM_W{1'b1}};
                            sat_next        = 1'b1;
                        end
                        else
                        begin
                            mass_total_next = mass_sum_wide[MASS_SUM_W-1:0];
                        end
                    end
                end
            end
            BK_ISSUE:
            begin
                if (s0_last)
                begin
                    state_next = BK_WAIT;
                end
                else if (ck_reg == LAST_TAP)
                begin
                    ck_next = 2'd0;
                    if (cj_reg == LAST_TAP)
                    begin
                        cj_next = 2'd0;
                        ci_next = ci_reg + 2'd1;
                    end
                    else
                    begin
                        cj_next = cj_reg + 2'd1;
                    end
                end
                else
                begin
                    ck_next = ck_reg + 2'd1;
                end
            end
            BK_WAIT:
            begin
                if (s4_valid_reg && s4_last_reg)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            clr_cnt_reg    <= '0;
            ci_reg         <= 2'd0;
            cj_reg         <= 2'd0;
            ck_reg         <= 2'd0;
            mass_total_reg <= '0;
            sat_reg        <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ci_reg         <= ci_next;
            cj_reg         <= cj_next;
            ck_reg         <= ck_next;
            mass_total_reg <= mass_total_next;
            sat_reg        <= sat_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            s1_valid_reg <= s0_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (s4_valid_reg && s4_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            item_reg <= pop_item;
        end
        s1_last_reg <= s0_last;
        s1_read_reg <= item_reg.op == OP_READ;
        s1_addr_reg <= s0_addr;
        s1_wz_reg   <= item_reg.wz[ck_reg][F-1:0];
        s1_p1_reg   <= s0_p1;

        s2_last_reg <= s1_last_reg;
        s2_read_reg <= s1_read_reg;
        s2_addr_reg <= s1_addr_reg;
        s2_p2_reg   <= s1_p1_reg[2*F-1:F] * s1_wz_reg;

        s3_last_reg <= s2_last_reg;
        s3_read_reg <= s2_read_reg;
        s3_addr_reg <= s2_addr_reg;
        s3_hi_reg   <= item_reg.rate[RATE_W-1:RATE_LO_W] * s2_w;
        s3_lo_reg   <= item_reg.rate[RATE_LO_W-1:0] * s2_w;

        s4_last_reg <= s3_last_reg;
        s4_read_reg <= s3_read_reg;
        s4_addr_reg <= s3_addr_reg;
        s4_amt_reg  <= s3_full[F +: GRID_W];

        if (s4_valid_reg && s4_last_reg)
        begin
            out_first_reg     <= s4_read_reg ? rdata_reg[GRID_W-1:0] : '0;
            out_second_reg    <= s4_read_reg ? rdata_reg[2*GRID_W-1:GRID_W] : '0;
            out_mass_sum_reg  <= mass_total_reg;
            out_saturated_reg <= sat_reg | grid_sat;
        end
    end

    // Grid memory: one read and one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            grid_mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            grid_mem[s4_addr_reg] <= wr_word;
        end
        rdata_reg <= grid_mem[s3_addr_reg];
    end

    assign out_valid     = out_valid_reg;
    assign out_first     = out_first_reg;
    assign out_second    = out_second_reg;
    assign out_mass_sum  = out_mass_sum_reg;
    assign out_saturated = out_saturated_reg;

endmodule

>>> sim/tb_tsc_mass_deposit_split_grid_core.sv
`timescale 1ns / 100ps

module tb_tsc_mass_deposit_split_grid_core;

    import tmdsg_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        op_t         op;
        logic [21:0] pos_x;
        logic [21:0] pos_y;
        logic [21:0] pos_z;
        logic [15:0] mass;
        logic        half;
        logic [17:0] read_cell;
    } particle_item_t;

    typedef struct {
        longint unsigned first_value;
        longint unsigned second_value;
        longint unsigned mass_sum;
        logic            saturated;
    } density_readout_t;

    class density_scoreboard;
        longint unsigned  first_grid[int];
        longint unsigned  second_grid[int];
        longint unsigned  mass_total;
        logic             sat_flag;
        longint unsigned  inv_volume;
        int               mismatches;
        int               touched_nodes[$];
        density_readout_t expected_readouts[$];

        function new();
            mass_total = 0;
            sat_flag   = 1'b0;
            inv_volume = 64'd65536;
            mismatches = 0;
        endfunction

        // Nearest node of one axis and the triangular-shaped-cloud weights at -1, 0, +1.
        function void tsc_axis(input logic [21:0] p, output logic [5:0] node,
                               output longint unsigned w[3]);
            longint unsigned d, s, a, b, wa, wb;
            logic up;
            d  = p[15:0];
            up = d >= 64'd32768;
            s  = up ? 64'd65536 - d : d;
            a  = 64'd32768 + s;
            b  = 64'd32768 - s;
            wa = (a * a) >> 17;
            wb = (b * b) >> 17;
            w[1] = ((64'd3 << 30) - s * s) >> 16;
            w[0] = up ? wa : wb;
            w[2] = up ? wb : wa;
            node = p[21:16] + {5'd0, up};
        endfunction

        function void note_item(particle_item_t it);
            density_readout_t exp_r;
            logic [5:0] nx, ny, nz, cx, cy, cz;
            longint unsigned wx[3], wy[3], wz[3];
            longint unsigned rate, wxy, wgt, sum;
            int idx;
            exp_r.first_value  = 0;
            exp_r.second_value = 0;
            if (it.op == OP_READ) begin
                idx = it.read_cell;
                if (first_grid.exists(idx))
                    exp_r.first_value = first_grid[idx];
                if (second_grid.exists(idx))
                    exp_r.second_value = second_grid[idx];
            end else begin
                tsc_axis(it.pos_x, nx, wx);
                tsc_axis(it.pos_y, ny, wy);
                tsc_axis(it.pos_z, nz, wz);
                rate = (longint'(it.mass) * inv_volume) >> 8;
                mass_total = mass_total + it.mass;
                if (mass_total > 64'hFFFF_FFFF_FFFF) begin
                    mass_total = 64'hFFFF_FFFF_FFFF;
                    sat_flag   = 1'b1;
                end
                touched_nodes.push_back({nx, ny, nz});
                if (touched_nodes.size() > 64)
                    void'(touched_nodes.pop_front());
                for (int i = 0; i < 3; i++) begin
                    cx = nx + 6'(i) - 6'd1;
                    for (int j = 0; j < 3; j++) begin
                        cy  = ny + 6'(j) - 6'd1;
                        wxy = (wx[i] * wy[j]) >> 16;
                        for (int k = 0; k < 3; k++) begin
                            cz  = nz + 6'(k) - 6'd1;
                            wgt = (wxy * wz[k]) >> 16;
                            idx = {cx, cy, cz};
                            if (it.half) begin
                                sum = (second_grid.exists(idx) ? second_grid[idx] : 0)
                                      + ((rate * wgt) >> 16);
                            end else begin
                                sum = (first_grid.exists(idx) ? first_grid[idx] : 0)
                                      + ((rate * wgt) >> 16);
                            end
                            if (sum > 64'hFF_FFFF_FFFF) begin
                                sum      = 64'hFF_FFFF_FFFF;
                                sat_flag = 1'b1;
                            end
                            if (it.half)
                                second_grid[idx] = sum;
                            else
                                first_grid[idx] = sum;
                        end
                    end
                end
            end
            exp_r.mass_sum  = mass_total;
            exp_r.saturated = sat_flag;
            expected_readouts.push_back(exp_r);
        endfunction

        task report_mismatch(string field, longint unsigned got, longint unsigned want);
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
            mismatches++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] d);
            density_readout_t exp_r;
            if (expected_readouts.size() == 0) begin
                report_mismatch("unexpected transfer", d[127:80], 0);
                return;
            end
            exp_r = expected_readouts.pop_front();
            if (d[39:0] !== exp_r.first_value[39:0])
                report_mismatch("first_grid_value", d[39:0], exp_r.first_value);
            if (d[79:40] !== exp_r.second_value[39:0])
                report_mismatch("second_grid_value", d[79:40], exp_r.second_value);
            if (d[127:80] !== exp_r.mass_sum[47:0])
                report_mismatch("mass_sum", d[127:80], exp_r.mass_sum);
            if (d[128] !== exp_r.saturated)
                report_mismatch("saturated", d[128], exp_r.saturated);
        endtask

        function int pending();
            return expected_readouts.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata;
    logic [IN_TUSER_W-1:0]     s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [ICV_W-1:0]          cfg_data;

    density_scoreboard sb;
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int cycle_count;

    tsc_mass_deposit_split_grid_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[tsc_mass_deposit_split_grid_core] ERROR");
            $finish;
        end
    end

    // The receiver counts down a long hold-off on its own, otherwise stalls at random.
    always @(posedge clk)
    begin
        if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Sampling at the falling edge sees the values that the next rising edge acts on.
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    function automatic particle_item_t mk_item(op_t op, logic [21:0] x, logic [21:0] y,
                                               logic [21:0] z, logic [15:0] m,
                                               logic h, logic [17:0] c);
        particle_item_t it;
        it.op        = op;
        it.pos_x     = x;
        it.pos_y     = y;
        it.pos_z     = z;
        it.mass      = m;
        it.half      = h;
        it.read_cell = c;
        return it;
    endfunction

    task offer_item(particle_item_t it);
        logic taken;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, it.read_cell, it.mass, it.pos_z, it.pos_y, it.pos_x};
        s_axis_tuser  <= {it.half, it.op};
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = s_axis_tready;
            if (taken)
                sb.note_item(it);
            @(posedge clk);
        end
    endtask

    task drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task write_inv_volume(logic [ICV_W-1:0] value);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        sb.inv_volume = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [21:0] rand_position();
        if ($urandom_range(0, 1))
            return 22'($urandom);
        // Crowd particles around the wrap seam so their clouds overlap.
        return {6'($urandom_range(0, 3) + 62), 16'($urandom)};
    endfunction

    task random_run(int count, logic deposits_only);
        particle_item_t it;
        int node;
        for (int n = 0; n < count; n++) begin
            it = mk_item(OP_DEPOSIT, rand_position(), rand_position(), rand_position(),
                         16'($urandom), 1'($urandom), 18'($urandom));
            if (!deposits_only && $urandom_range(0, 99) < 35) begin
                it.op = OP_READ;
                if (sb.touched_nodes.size() != 0 && $urandom_range(0, 3) != 0) begin
                    node = sb.touched_nodes[$urandom_range(0, sb.touched_nodes.size() - 1)];
                    it.read_cell = {6'(node[17:12] + $urandom_range(0, 2) - 1),
                                    6'(node[11:6] + $urandom_range(0, 2) - 1),
                                    6'(node[5:0] + $urandom_range(0, 2) - 1)};
                end
            end
            offer_item(it);
        end
    endtask

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        m_axis_tready   = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_cycles     = 0;
        cycle_count     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_inv_volume(32'h0001_0000);
        // Cloud corners at the origin and at the far end wrap onto each other.
        offer_item(mk_item(OP_DEPOSIT, 22'd0, 22'd0, 22'd0, 16'h0100, 1'b0, 18'd0));
        offer_item(mk_item(OP_DEPOSIT, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 16'hFFFF,
                           1'b1, 18'h3FFFF));
        offer_item(mk_item(OP_DEPOSIT, {6'd5, 16'h7FFF}, {6'd5, 16'h7FFF}, {6'd5, 16'h7FFF},
                           16'h0280, 1'b0, 18'd0));
        offer_item(mk_item(OP_DEPOSIT, {6'd5, 16'h8000}, {6'd5, 16'h8000}, {6'd5, 16'h8000},
                           16'h0003, 1'b1, 18'd0));
        offer_item(mk_item(OP_DEPOSIT, {6'd20, 16'h4000}, {6'd31, 16'hC000}, {6'd7, 16'h0001},
                           16'h0000, 1'b0, 18'd0));
        offer_item(mk_item(OP_DEPOSIT, {6'd63, 16'hFFFF}, {6'd0, 16'h0000}, {6'd63, 16'h8000},
                           16'h1234, 1'b0, 18'd0));
        offer_item(mk_item(OP_READ, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 16'hFFFF, 1'b1,
                           18'd0));
        offer_item(mk_item(OP_READ, 22'd0, 22'd0, 22'd0, 16'd0, 1'b0, 18'h3FFFF));
        offer_item(mk_item(OP_READ, 22'd0, 22'd0, 22'd0, 16'd0, 1'b0, 18'd1));
        offer_item(mk_item(OP_READ, 22'd0, 22'd0, 22'd0, 16'd0, 1'b0, 18'd20805));
        offer_item(mk_item(OP_READ, 22'd0, 22'd0, 22'd0, 16'd0, 1'b1, 18'd24966));
        offer_item(mk_item(OP_READ, 22'd0, 22'd0, 22'd0, 16'd0, 1'b0, 18'd4096));
        random_run(340, 1'b0);

        drain_results();
        write_inv_volume(32'h0000_0000);
        sender_idle_pct = 80;
        random_run(300, 1'b0);

        drain_results();
        write_inv_volume(32'hFFFF_FFFF);
        sender_idle_pct = 0;
        recv_stall_pct  = 80;
        // Heavy particles on one node drive its cell past the grid limit.
        repeat (4)
            offer_item(mk_item(OP_DEPOSIT, {6'd10, 16'h0}, {6'd10, 16'h0}, {6'd10, 16'h0},
                               16'hFFFF, 1'b0, 18'd0));
        offer_item(mk_item(OP_READ, 22'd0, 22'd0, 22'd0, 16'd0, 1'b0, 18'd41610));
        random_run(300, 1'b0);

        recv_stall_pct = 0;
        hold_cycles    = 3000;
        random_run(40, 1'b1);

        drain_results();
        write_inv_volume(ICV_W'($urandom));
        sender_idle_pct = 28;
        recv_stall_pct  = 28;
        random_run(340, 1'b0);

        drain_results();
        if (sb.mismatches == 0)
            $display("[tsc_mass_deposit_split_grid_core] OK");
        else
            $display("[tsc_mass_deposit_split_grid_core] ERROR");
        $finish;
    end

endmodule
